/* hw/rtl/imf_pkg.sv */
// Shared types and constants of the image median filter.
`default_nettype none
package imf_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_FILT  = 3;
    localparam int FILT_W    = CHAN_W * NUM_FILT;
    localparam int PIX_W     = 4 * CHAN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP     = 2'd3;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_BPP    = 3;
    localparam int RESET_STEP   = 3;

    typedef struct packed {
        logic              valid;
        logic [NUM_FILT-1:0] gt;
        logic [FILT_W-1:0] val;
    } link_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CALC   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/imf_cell.sv */
// One cell of the insertion sorting chain, holding one sorted value per filtered channel.
`default_nettype none
module imf_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      ins,
    input  wire logic [imf_pkg::FILT_W-1:0] v,
    input  imf_pkg::link_t                 left,
    output imf_pkg::link_t                 self_link
);

    logic                          valid_reg;
    logic [imf_pkg::FILT_W-1:0]    val_reg;
    logic [imf_pkg::NUM_FILT-1:0]  gt;
    logic [imf_pkg::FILT_W-1:0]    val_next;

    always_comb begin
        val_next = val_reg;
        for (int j = 0; j < imf_pkg::NUM_FILT; j++) begin
            gt[j] = !valid_reg ||
                    (val_reg[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W] >
                     v[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W]);
            if (gt[j]) begin
                if (!FIRST && left.gt[j]) begin
                    val_next[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W] =
                        left.val[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W];
                end else begin
                    val_next[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W] =
                        v[j*imf_pkg::CHAN_W +: imf_pkg::CHAN_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
        end else if (ins) begin
            valid_reg <= valid_reg | (FIRST ? 1'b1 : left.valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (ins) begin
            val_reg <= val_next;
        end
    end

    assign self_link.valid = valid_reg;
    assign self_link.gt    = gt;
    assign self_link.val   = val_reg;

endmodule
`default_nettype wire

/* hw/rtl/imf_sorter.sv */
// Chain of sorting cells with selection of the middle value.
`default_nettype none
module imf_sorter #(
    parameter int DEPTH = 49,
    parameter int SEL_W = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      ins,
    input  wire logic [imf_pkg::FILT_W-1:0] v,
    input  wire logic [SEL_W-1:0]          sel,
    output logic [imf_pkg::FILT_W-1:0]     median
);

    imf_pkg::link_t links [DEPTH];
    imf_pkg::link_t head;

    assign head = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        imf_cell #(.FIRST(i == 0)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (clear),
            .ins       (ins),
            .v         (v),
            .left      ((i == 0) ? head : links[(i == 0) ? 0 : i-1]),
            .self_link (links[i])
        );
    end

    assign median = links[sel].val;

endmodule
`default_nettype wire

/* hw/rtl/image_median_filter.sv */
// Top level of the streaming square-window median filter.
// An input transaction that causes no result passes the calc and decide states before the next one.
// A result also sweeps the window pixels inside the image (up to 49), then drains and is emitted:
// one line store read per window pixel, each value entering the chain after the read data register.
// Results leave through an output register; a waiting one blocks input only once the next is ready.
// Reset is synchronous and active low; it clears counters, control and the sorting chain.
// The line store is not cleared and needs no clearing pass.
`default_nettype none
module image_median_filter #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int ROWO_W = $clog2(MAX_HEIGHT),
    localparam int OUT_BITS = imf_pkg::PIX_W + COL_W + ROWO_W,
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // in_chan0, in_chan1, in_chan2, in_chan3
    input  wire logic [imf_pkg::PIX_W-1:0]     s_tdata,
    // mode
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_chan0, out_chan1, out_chan2, out_chan3, out_col, out_row, zero padding
    output logic [OUT_DATA_W-1:0]              m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [imf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [imf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int RING_W  = $clog2(MAX_WINDOW + 1);
    localparam int NH_W    = RING_W;
    localparam int IDX_W   = ROW_W + WID_W + 1;
    localparam int WIN_CAP = MAX_WINDOW * MAX_WINDOW;
    localparam int K_W     = (WIN_CAP > 1) ? $clog2(WIN_CAP) : 1;
    localparam int SIDE_CAP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
    localparam int MEM_DEPTH = 1 << (RING_W + COL_W);
    localparam int CH_W = imf_pkg::CHAN_W;

    logic [imf_pkg::PIX_W-1:0] line_mem [MEM_DEPTH];

    imf_pkg::state_t state_reg;
    logic [WID_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [2:0]       bpp_reg;
    logic [2:0]       step_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg, x_reg, c0_reg, c1_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg, y_reg, r1_reg;
    logic [IDX_W-1:0] in_idx_reg, out_idx_reg, lag_reg;
    logic [imf_pkg::PIX_W-1:0] rd_data_reg;
    logic             rd_valid_reg, centre_d_reg, drain_reg;
    logic [CH_W-1:0]  chan3_reg;
    logic [K_W-1:0]   k_reg;
    logic             m_tvalid_reg, m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [NH_W-1:0]  nh;
    logic [3:0]       side;
    logic             in_done, due, accept, out_free, frame_end, sweep;
    logic [ROW_W:0]   r_hi, r_lim;
    logic [COL_W+1:0] c_hi, c_lim;
    logic [ROW_W-1:0] r0_next, r1_next;
    logic [COL_W-1:0] c0_next, c1_next;
    logic [IDX_W-1:0] lag_col;
    logic [1:0]       nf;
    logic             sort_clear;
    logic [imf_pkg::FILT_W-1:0] median;
    logic [CH_W-1:0]  med0, med1, med2, ch3;
    logic [WID_W-1:0] in_col_inc;
    logic [RING_W+COL_W-1:0] wr_addr, rd_addr;
    logic [11:0] cfg_w;
    logic [12:0] cfg_h;
    logic [2:0]  cfg_b;

    always_comb begin
        side = {1'b0, step_reg | 3'd1};
        if (int'(side) > SIDE_CAP) begin
            side = 4'(SIDE_CAP);
        end
        nh = NH_W'(side >> 1);
    end

    assign in_done    = in_row_reg >= height_reg;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign sweep      = state_reg == imf_pkg::ST_SWEEP;
    assign in_col_inc = WID_W'(in_col_reg) + WID_W'(1);
    assign due        = in_done || ((out_idx_reg + lag_reg) < in_idx_reg);
    assign frame_end  = ((ROW_W+1)'(out_row_reg) + (ROW_W+1)'(1) >= (ROW_W+1)'(height_reg)) &&
                        (WID_W'(out_col_reg) + WID_W'(1) >= width_reg);
    assign sort_clear = (state_reg == imf_pkg::ST_DECIDE) && due;
    assign lag_col    = (WID_W'(nh) < width_reg - WID_W'(1)) ? IDX_W'(nh)
                                                             : IDX_W'(width_reg - WID_W'(1));
    assign wr_addr    = {in_row_reg[RING_W-1:0], in_col_reg};
    assign rd_addr    = {y_reg[RING_W-1:0], x_reg};
    assign nf         = (bpp_reg >= 3'd3) ? 2'd3 : bpp_reg[1:0];

    always_comb begin
        r_hi = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(nh);
        r_lim = (ROW_W+1)'(height_reg) - (ROW_W+1)'(1);
        c_hi = (COL_W+2)'(out_col_reg) + (COL_W+2)'(nh);
        c_lim = (COL_W+2)'(width_reg) - (COL_W+2)'(1);
        r0_next = (out_row_reg >= ROW_W'(nh)) ? out_row_reg - ROW_W'(nh) : '0;
        r1_next = (r_hi < r_lim) ? ROW_W'(r_hi) : ROW_W'(r_lim);
        c0_next = (out_col_reg >= COL_W'(nh)) ? out_col_reg - COL_W'(nh) : '0;
        c1_next = (c_hi < c_lim) ? COL_W'(c_hi) : COL_W'(c_lim);
    end

    always_comb begin
        cfg_w = cfg_data[11:0];
        cfg_h = cfg_data[12:0];
        cfg_b = cfg_data[2:0];
        if (cfg_w == '0) begin
            cfg_w = 12'd1;
        end else if (int'(cfg_w) > MAX_WIDTH) begin
            cfg_w = 12'(MAX_WIDTH);
        end
        if (cfg_h == '0) begin
            cfg_h = 13'd1;
        end else if (int'(cfg_h) > MAX_HEIGHT) begin
            cfg_h = 13'(MAX_HEIGHT);
        end
        if (cfg_b == '0) begin
            cfg_b = 3'd1;
        end else if (cfg_b > 3'd4) begin
            cfg_b = 3'd4;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tuser && !in_done) begin
            line_mem[wr_addr] <= s_tdata;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            centre_d_reg <= 1'b0;
        end else begin
            rd_valid_reg <= sweep;
            centre_d_reg <= sweep && (y_reg == out_row_reg) && (x_reg == out_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (centre_d_reg) begin
            chan3_reg <= rd_data_reg[3*CH_W +: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= imf_pkg::ST_IDLE;
            width_reg    <= WID_W'(imf_pkg::RESET_WIDTH);
            height_reg   <= ROW_W'(imf_pkg::RESET_HEIGHT);
            bpp_reg      <= 3'(imf_pkg::RESET_BPP);
            step_reg     <= 3'(imf_pkg::RESET_STEP);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            k_reg        <= '0;
            drain_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (rd_valid_reg && (int'(k_reg) < WIN_CAP - 1)) begin
                k_reg <= k_reg + K_W'(1);
            end
            if (cfg_we) begin
                case (cfg_index)
                    imf_pkg::REG_IMAGE_WIDTH:     width_reg  <= WID_W'(cfg_w);
                    imf_pkg::REG_IMAGE_HEIGHT:    height_reg <= ROW_W'(cfg_h);
                    imf_pkg::REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_b;
                    imf_pkg::REG_WINDOW_STEP:     step_reg   <= cfg_data[2:0];
                    default: ;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            case (state_reg)
                imf_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (!s_tuser && !in_done) begin
                            if (in_col_inc >= width_reg) begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + ROW_W'(1);
                            end else begin
                                in_col_reg <= COL_W'(in_col_inc);
                            end
                        end
                        state_reg <= imf_pkg::ST_CALC;
                    end
                end
                imf_pkg::ST_CALC: begin
                    in_idx_reg  <= IDX_W'(in_row_reg) * IDX_W'(width_reg) + IDX_W'(in_col_reg);
                    out_idx_reg <= IDX_W'(out_row_reg) * IDX_W'(width_reg) + IDX_W'(out_col_reg);
                    lag_reg     <= IDX_W'(nh) * IDX_W'(width_reg) + lag_col;
                    state_reg   <= imf_pkg::ST_DECIDE;
                end
                imf_pkg::ST_DECIDE: begin
                    if (due) begin
                        r1_reg    <= r1_next;
                        c0_reg    <= c0_next;
                        c1_reg    <= c1_next;
                        y_reg     <= r0_next;
                        x_reg     <= c0_next;
                        k_reg     <= '0;
                        state_reg <= imf_pkg::ST_SWEEP;
                    end else begin
                        state_reg <= imf_pkg::ST_IDLE;
                    end
                end
                imf_pkg::ST_SWEEP: begin
                    if (x_reg == c1_reg) begin
                        x_reg <= c0_reg;
                        if (y_reg == r1_reg) begin
                            drain_reg <= 1'b0;
                            state_reg <= imf_pkg::ST_DRAIN;
                        end else begin
                            y_reg <= y_reg + ROW_W'(1);
                        end
                    end else begin
                        x_reg <= x_reg + COL_W'(1);
                    end
                end
                imf_pkg::ST_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= imf_pkg::ST_EMIT;
                    end
                end
                imf_pkg::ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= frame_end;
                        m_tdata_reg  <= OUT_DATA_W'({ROWO_W'(out_row_reg), out_col_reg,
                                                     ch3, med2, med1, med0});
                        if (frame_end) begin
                            in_col_reg  <= '0;
                            in_row_reg  <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                        end else if (WID_W'(out_col_reg) + WID_W'(1) >= width_reg) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ROW_W'(1);
                        end else begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                        state_reg <= imf_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= imf_pkg::ST_IDLE;
            endcase
        end
    end

    imf_sorter #(
        .DEPTH (WIN_CAP),
        .SEL_W (K_W)
    ) u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (sort_clear),
        .ins     (rd_valid_reg),
        .v       (rd_data_reg[imf_pkg::FILT_W-1:0]),
        .sel     (k_reg >> 1),
        .median  (median)
    );

    assign med0 = (nf > 2'd0) ? median[0*CH_W +: CH_W] : '0;
    assign med1 = (nf > 2'd1) ? median[1*CH_W +: CH_W] : '0;
    assign med2 = (nf > 2'd2) ? median[2*CH_W +: CH_W] : '0;
    assign ch3  = (bpp_reg == 3'd4) ? chan3_reg : '0;

    assign s_tready = state_reg == imf_pkg::ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

/* hw/rtl/imf_checker.sv */
// Port-level checker of the median filter and its binding to the top level.
`default_nettype none
module imf_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int OUT_DATA_W = 56
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [OUT_DATA_W-1:0]         m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          cfg_we
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROWO_W = $clog2(MAX_HEIGHT);

    logic             at_origin_reg;
    logic [COL_W-1:0] prev_col_reg;
    logic             out_xfer;
    logic [COL_W-1:0] col;
    logic [ROWO_W-1:0] row;

    assign out_xfer = m_tvalid && m_tready;
    assign col = m_tdata[imf_pkg::PIX_W +: COL_W];
    assign row = m_tdata[imf_pkg::PIX_W + COL_W +: ROWO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_origin_reg <= 1'b1;
            prev_col_reg  <= '0;
        end else begin
            if (out_xfer) begin
                at_origin_reg <= m_tlast;
                prev_col_reg  <= col;
            end
            if (cfg_we) begin
                at_origin_reg <= 1'b1;
            end
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid directly after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result transaction changed.");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && at_origin_reg |-> (col == '0) && (row == '0))
        else $error("First result of a frame is not at the origin.");

    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && !at_origin_reg |-> (col == prev_col_reg + COL_W'(1)) || (col == '0))
        else $error("Result columns out of raster order.");

endmodule

bind image_median_filter imf_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .OUT_DATA_W (OUT_DATA_W)
) u_imf_checker (.*);
`default_nettype wire
